@@ design/hmtp_pkg.sv @@
// ----------------------------------------------------------------------------
// hmtp_pkg
// Shared types and constants of the height-map text parser.
// ----------------------------------------------------------------------------
package hmtp_pkg;

    // Default and widest coordinate counter width
    localparam int COORD_BITS     = 12;
    localparam int MAX_COORD_BITS = 16;

    // Width of the grid size registers
    localparam int CFG_BITS = 13;

    // Register indexes on the configuration port
    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_DEPTH = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Colour given to a cell without an explicit colour
    localparam logic [23:0] DEFAULT_COLOR = 24'hFFFFFF;

    // One result beat; row and column are held at the widest coordinate width
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [31:0]        altitude;
        logic [23:0]               color;
        logic [MAX_COORD_BITS-1:0] row;
        logic [MAX_COORD_BITS-1:0] col;
        logic signed [31:0]        height_min;
        logic signed [31:0]        height_max;
        logic                      color_seen;
        logic                      last_cell;
    } result_t;

endpackage

@@ design/hmtp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hmtp_cfg_regs
// APB register file holding the grid width and depth.
// ----------------------------------------------------------------------------
module hmtp_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [hmtp_pkg::CFG_BITS-1:0] grid_width,
    output logic [hmtp_pkg::CFG_BITS-1:0] grid_depth
);

    logic [hmtp_pkg::CFG_BITS-1:0] width_reg;
    logic [hmtp_pkg::CFG_BITS-1:0] depth_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= hmtp_pkg::CFG_BITS'(1);
            depth_reg <= hmtp_pkg::CFG_BITS'(1);
        end
        else if (wr_en)
        begin
            if (reg_sel == hmtp_pkg::REG_GRID_WIDTH)
                width_reg <= pwdata[hmtp_pkg::CFG_BITS-1:0];
            else
                depth_reg <= pwdata[hmtp_pkg::CFG_BITS-1:0];
        end
    end

    always_comb
    begin
        if (reg_sel == hmtp_pkg::REG_GRID_WIDTH)
            prdata = 32'(width_reg);
        else
            prdata = 32'(depth_reg);
    end

    assign grid_width = width_reg;
    assign grid_depth = depth_reg;

endmodule

@@ design/hmtp_engine.sv @@
// ----------------------------------------------------------------------------
// hmtp_engine
// Parse state machine: one character per step, result beat registered.
// ----------------------------------------------------------------------------
module hmtp_engine
#(
    parameter int COORD_BITS = hmtp_pkg::COORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    char_byte,
    input  logic                          end_of_file,
    input  logic [hmtp_pkg::CFG_BITS-1:0] grid_width,
    input  logic [hmtp_pkg::CFG_BITS-1:0] grid_depth,
    output logic                          result_emit,
    output hmtp_pkg::result_t             result
);

    localparam int SIZE_W = hmtp_pkg::MAX_COORD_BITS + 1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [31:0] MAG_LIMIT  = 32'd214748364;
    localparam logic [3:0]  LAST_DIGIT = 4'd8;
    localparam logic [2:0]  HEX_DIGITS = 3'd6;

    typedef enum logic [2:0] {
        PH_START,
        PH_SKIP,
        PH_MINUS,
        PH_DIGITS,
        PH_COLOR0,
        PH_COLORX,
        PH_HEX,
        PH_TRAIL
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   nl_reg, nl_next;
    logic [2:0]             hex_reg, hex_next;
    logic [23:0]            color_reg, color_next;
    logic [COORD_BITS-1:0]  row_reg, row_next;
    logic [COORD_BITS-1:0]  col_reg, col_next;
    logic signed [31:0]     min_reg, min_next;
    logic signed [31:0]     max_reg, max_next;
    logic                   any_reg, any_next;
    logic                   err_reg, err_next;
    hmtp_pkg::result_t      res_reg, res_next;

    logic                   is_digit, is_blank, is_ws, is_hex;
    logic [3:0]             digit_val, hex_val;
    logic                   overflow;
    logic [31:0]            mag_x10;
    logic [SIZE_W-1:0]      size_top, width_raw, depth_raw, width_eff, depth_eff;
    logic [SIZE_W-1:0]      col_inc, row_inc;
    logic                   col_end, row_end, grid_last;
    logic signed [31:0]     cell_alt, new_min, new_max;
    logic                   first_cell;
    logic                   emit, do_fail, do_finish, fin_color, run_start, run_digit;

    // Character classes
    assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign is_blank  = (char_byte == CH_SPACE) || (char_byte == CH_TAB);
    assign is_ws     = is_blank || (char_byte == CH_NL);
    assign digit_val = 4'(char_byte - CH_ZERO);

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = digit_val;
        if (is_digit)
            hex_val = digit_val;
        else if ((char_byte >= CH_UP_A) && (char_byte <= CH_UP_F))
            hex_val = 4'(char_byte - CH_UP_A + 8'd10);
        else if ((char_byte >= CH_LO_A) && (char_byte <= CH_LO_F))
            hex_val = 4'(char_byte - CH_LO_A + 8'd10);
        else
            is_hex = 1'b0;
    end

    // Magnitude step; -2147483648 is the only value allowed to reach the limit+8
    assign overflow = (mag_reg > MAG_LIMIT) ||
                      ((mag_reg == MAG_LIMIT) &&
                       ((digit_val > LAST_DIGIT) || ((digit_val == LAST_DIGIT) && !neg_reg)));
    assign mag_x10  = {mag_reg[28:0], 3'b000} + {mag_reg[30:0], 1'b0} + 32'(digit_val);

    // Grid limits, clamped to 1 .. 2^COORD_BITS
    assign size_top  = SIZE_W'(1) << COORD_BITS;
    assign width_raw = SIZE_W'(grid_width);
    assign depth_raw = SIZE_W'(grid_depth);
    assign width_eff = (width_raw == '0) ? SIZE_W'(1) :
                       (width_raw > size_top) ? size_top : width_raw;
    assign depth_eff = (depth_raw == '0) ? SIZE_W'(1) :
                       (depth_raw > size_top) ? size_top : depth_raw;
    assign col_inc   = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc   = SIZE_W'(row_reg) + SIZE_W'(1);
    assign col_end   = col_inc >= width_eff;
    assign row_end   = row_inc >= depth_eff;
    assign grid_last = col_end && row_end;

    // Finished cell value and running extremes
    assign cell_alt   = neg_reg ? $signed(32'd0 - mag_reg) : $signed(mag_reg);
    assign first_cell = (row_reg == '0) && (col_reg == '0);
    assign new_min    = (first_cell || (cell_alt < min_reg)) ? cell_alt : min_reg;
    assign new_max    = (first_cell || (cell_alt > max_reg)) ? cell_alt : max_reg;

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        nl_next    = nl_reg;
        hex_next   = hex_reg;
        color_next = color_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        any_next   = any_reg;
        err_next   = err_reg;
        res_next   = '0;
        emit       = 1'b0;
        do_fail    = 1'b0;
        do_finish  = 1'b0;
        fin_color  = 1'b0;
        run_start  = 1'b0;
        run_digit  = 1'b0;

        if (!err_reg)
        begin
            case (phase_reg)
                PH_TRAIL:
                begin
                    if (end_of_file)
                    begin
                        emit          = 1'b1;
                        res_next.kind = hmtp_pkg::KIND_DONE;
                    end
                    else if (!is_ws)
                        do_fail = 1'b1;
                end
                PH_MINUS:
                begin
                    if (!end_of_file && is_digit)
                        run_digit = 1'b1;
                    else
                        do_fail = 1'b1;
                end
                PH_DIGITS:
                begin
                    if (end_of_file)
                        do_finish = 1'b1;
                    else
                        run_digit = 1'b1;
                end
                PH_COLOR0:
                begin
                    if (!end_of_file && (char_byte == CH_ZERO))
                        phase_next = PH_COLORX;
                    else
                        do_fail = 1'b1;
                end
                PH_COLORX:
                begin
                    if (!end_of_file && ((char_byte == CH_UP_X) || (char_byte == CH_LO_X)))
                    begin
                        phase_next = PH_HEX;
                        hex_next   = '0;
                        color_next = '0;
                    end
                    else
                        do_fail = 1'b1;
                end
                PH_HEX:
                begin
                    fin_color = 1'b1;
                    if (end_of_file)
                        do_finish = 1'b1;
                    else if (is_hex && (hex_reg < HEX_DIGITS))
                    begin
                        color_next = {color_reg[19:0], hex_val};
                        hex_next   = hex_reg + 3'd1;
                    end
                    else if (is_ws)
                        do_finish = 1'b1;
                    else
                        do_fail = 1'b1;
                end
                PH_SKIP:
                begin
                    if (end_of_file)
                        do_finish = 1'b1;
                    else
                        run_start = 1'b1;
                end
                default:
                begin
                    if (end_of_file)
                        do_fail = 1'b1;
                    else
                        run_start = 1'b1;
                end
            endcase
        end

        // Cell start: a blank re-arms the single newline skip
        if (run_start)
        begin
            if (is_blank)
            begin
                nl_next    = 1'b0;
                phase_next = PH_SKIP;
            end
            else if ((char_byte == CH_NL) && !nl_reg)
            begin
                nl_next    = 1'b1;
                phase_next = PH_SKIP;
            end
            else if (char_byte == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_MINUS;
            end
            else
                run_digit = 1'b1;
        end

        if (run_digit)
        begin
            if (is_digit)
            begin
                if (overflow)
                    do_fail = 1'b1;
                else
                begin
                    mag_next   = mag_x10;
                    phase_next = PH_DIGITS;
                end
            end
            else if (char_byte == CH_COMMA)
            begin
                any_next   = 1'b1;
                phase_next = PH_COLOR0;
            end
            else if (is_ws)
                do_finish = 1'b1;
            else
                do_fail = 1'b1;
        end

        if (do_finish)
        begin
            emit              = 1'b1;
            min_next          = new_min;
            max_next          = new_max;
            res_next.altitude = cell_alt;
            res_next.color    = fin_color ? color_reg : hmtp_pkg::DEFAULT_COLOR;
            res_next.row      = hmtp_pkg::MAX_COORD_BITS'(row_reg);
            res_next.col      = hmtp_pkg::MAX_COORD_BITS'(col_reg);
            res_next.last_cell = grid_last;
            if (end_of_file)
            begin
                // End of file closes the grid only on its final cell
                if (!grid_last)
                    do_fail = 1'b1;
                res_next.kind = hmtp_pkg::KIND_DONE;
            end
            else
            begin
                res_next.kind = hmtp_pkg::KIND_CELL;
                if (col_end)
                begin
                    col_next = '0;
                    if (row_end)
                        phase_next = PH_TRAIL;
                    else
                    begin
                        row_next   = row_inc[COORD_BITS-1:0];
                        phase_next = PH_START;
                    end
                end
                else
                begin
                    col_next   = col_inc[COORD_BITS-1:0];
                    phase_next = PH_START;
                end
                mag_next   = '0;
                color_next = '0;
                hex_next   = '0;
                neg_next   = 1'b0;
                nl_next    = 1'b0;
            end
        end

        if (do_fail)
        begin
            emit     = 1'b1;
            res_next = '0;
            res_next.kind = hmtp_pkg::KIND_ERROR;
            err_next = 1'b1;
        end

        res_next.height_min = min_next;
        res_next.height_max = max_next;
        res_next.color_seen = any_next;

        // End of file always returns the session to its reset state
        if (end_of_file)
        begin
            phase_next = PH_START;
            mag_next   = '0;
            neg_next   = 1'b0;
            nl_next    = 1'b0;
            hex_next   = '0;
            color_next = '0;
            row_next   = '0;
            col_next   = '0;
            min_next   = '0;
            max_next   = '0;
            any_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            nl_reg    <= 1'b0;
            hex_reg   <= '0;
            color_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            any_reg   <= 1'b0;
            err_reg   <= 1'b0;
            res_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            nl_reg    <= nl_next;
            hex_reg   <= hex_next;
            color_reg <= color_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            any_reg   <= any_next;
            err_reg   <= err_next;
            if (emit)
                res_reg <= res_next;
        end
    end

    assign result_emit = emit;
    assign result      = res_reg;

endmodule

@@ design/heightmap_text_parser_core.sv @@
// ----------------------------------------------------------------------------
// heightmap_text_parser_core
// Streaming parser of height-map text into cells with running min and max.
// ----------------------------------------------------------------------------
// Characters enter on the s_ stream, one per beat: s_tdata is the character,
// s_tlast marks end of file (the character is then ignored). Each accepted
// beat yields zero or one result beat on the m_ stream: m_tuser gives the kind
// (cell, error, file accepted), m_tlast marks the final cell of the grid.
// Grid width and depth are set over the APB port; the user must only write
// them while no file is in flight, the block does not enforce it. A beat is
// taken into an input register and parsed by the state machine; its result
// lands in the output register, which drives m_tvalid. One character per
// cycle is sustained while the receiver does not stall; the rate is set by the
// single state update of the parser. When the receiver stalls, the output
// register holds and the input register takes one more beat before s_tready
// drops. After an error, characters are dropped without result until end of
// file. Reset clears all parse state and sets both grid sizes to one.
// ----------------------------------------------------------------------------
module heightmap_text_parser_core
#(
    parameter int COORD_BITS = hmtp_pkg::COORD_BITS,
    localparam int OUT_BITS  = 121 + 2 * COORD_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // APB configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Character stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // char_byte
    input  logic             s_tlast,   // end_of_file
    // Result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // altitude, cell_color, cell_row, cell_col,
                                        // height_min, height_max, color_seen
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // last_cell
);

    logic [hmtp_pkg::CFG_BITS-1:0] grid_width;
    logic [hmtp_pkg::CFG_BITS-1:0] grid_depth;

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_eof_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step;
    logic              result_emit;
    hmtp_pkg::result_t result;

    hmtp_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .grid_width (grid_width),
        .grid_depth (grid_depth)
    );

    // Advance whenever the output register is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= step && result_emit;
        end
    end

    // Payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    hmtp_engine #(.COORD_BITS(COORD_BITS)) u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_byte   (in_char_reg),
        .end_of_file (in_eof_reg),
        .grid_width  (grid_width),
        .grid_depth  (grid_depth),
        .result_emit (result_emit),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result.kind;
    assign m_tlast  = result.last_cell;
    assign m_tdata  = OUT_W'({result.color_seen,
                              result.height_max,
                              result.height_min,
                              result.col[COORD_BITS-1:0],
                              result.row[COORD_BITS-1:0],
                              result.color,
                              result.altitude});

endmodule

@@ test/heightmap_text_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// heightmap_text_parser_core_tb
// Self-checking bench for the height-map text parser. Height-map text files
// are streamed in one character per beat, with random gaps on both streams.
// A software copy of the parser predicts every result beat, and a scoreboard
// checks each result against it field by field. Grid sizes are reprogrammed
// over APB between files, the clamped extremes among them.
// ----------------------------------------------------------------------------
module heightmap_text_parser_core_tb;

    localparam int CB      = hmtp_pkg::COORD_BITS;
    localparam int RES_W   = ((121 + 2 * CB + 7) / 8) * 8;
    localparam int ROW_LSB = 56;
    localparam int COL_LSB = 56 + CB;
    localparam int MIN_LSB = 56 + 2 * CB;
    localparam int MAX_LSB = 88 + 2 * CB;
    localparam int SEEN_BIT = 120 + 2 * CB;

    localparam int LIMIT_CYCLES     = 1000000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_BEATS     = 1000;
    localparam int HOLD_FILE        = 4;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CLAMP_CELLS      = 8;

    localparam logic [31:0] MAG_LIMIT = 32'd214748364;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_XL    = 8'h78;

    typedef enum logic [3:0] {
        ST_CELL, ST_BLANK, ST_SIGN, ST_DIGIT, ST_COMMA, ST_ZERO, ST_HEX, ST_TAIL
    } parse_state_t;

    // ------------------------------------------------------------------------
    // Parser prediction and result checking
    // ------------------------------------------------------------------------
    class height_scoreboard;
        int unsigned       width_reg;
        int unsigned       depth_reg;
        parse_state_t      phase;
        logic [31:0]       mag;
        bit                is_neg;
        bit                nl_taken;
        int unsigned       hex_digits;
        logic [23:0]       colour_acc;
        int unsigned       row_idx;
        int unsigned       col_idx;
        logic signed [31:0] lo_height;
        logic signed [31:0] hi_height;
        bit                colour_flag;
        bit                in_error;
        hmtp_pkg::result_t expected_cells[$];
        int unsigned       errors;

        function new();
            width_reg = 1;
            depth_reg = 1;
            errors = 0;
            clear_file();
        endfunction

        function void clear_file();
            phase = ST_CELL;
            mag = '0;
            is_neg = 1'b0;
            nl_taken = 1'b0;
            hex_digits = 0;
            colour_acc = '0;
            row_idx = 0;
            col_idx = 0;
            lo_height = '0;
            hi_height = '0;
            colour_flag = 1'b0;
            in_error = 1'b0;
        endfunction

        function int unsigned clamp_size(int unsigned v);
            if (v < 1)
                return 1;
            if (v > (1 << CB))
                return 1 << CB;
            return v;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_NL;
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9)
                return c - CH_0;
            if (c >= CH_UA && c <= CH_UF)
                return c - CH_UA + 10;
            if (c >= CH_LA && c <= CH_LF)
                return c - CH_LA + 10;
            return -1;
        endfunction

        function void add_result(logic [1:0] kind, logic signed [31:0] alt,
                                 logic [23:0] colour, int unsigned row,
                                 int unsigned col, bit last);
            hmtp_pkg::result_t r;
            r.kind       = kind;
            r.altitude   = alt;
            r.color      = colour;
            r.row        = {4'd0, row[11:0]};
            r.col        = {4'd0, col[11:0]};
            r.height_min = lo_height;
            r.height_max = hi_height;
            r.color_seen = colour_flag;
            r.last_cell  = last;
            expected_cells.push_back(r);
        endfunction

        function void raise_error(bit eof);
            add_result(hmtp_pkg::KIND_ERROR, '0, '0, 0, 0, 1'b0);
            if (eof)
                clear_file();
            else
                in_error = 1'b1;
        endfunction

        function void finish_cell(bit eof, bit has_colour);
            logic signed [31:0] alt;
            logic [23:0]        colour;
            int unsigned        w;
            int unsigned        d;
            bit                 last;
            alt = is_neg ? -mag : mag;
            colour = has_colour ? colour_acc : hmtp_pkg::DEFAULT_COLOR;
            w = clamp_size(width_reg);
            d = clamp_size(depth_reg);
            last = (col_idx + 1 >= w) && (row_idx + 1 >= d);
            // first cell of the file seeds the running extremes
            if (row_idx == 0 && col_idx == 0)
            begin
                lo_height = alt;
                hi_height = alt;
            end
            if (alt < lo_height)
                lo_height = alt;
            if (alt > hi_height)
                hi_height = alt;
            if (eof)
            begin
                if (!last)
                begin
                    raise_error(1'b1);
                    return;
                end
                add_result(hmtp_pkg::KIND_DONE, alt, colour, row_idx, col_idx, 1'b1);
                clear_file();
                return;
            end
            add_result(hmtp_pkg::KIND_CELL, alt, colour, row_idx, col_idx, last);
            if (col_idx + 1 >= w)
            begin
                col_idx = 0;
                if (row_idx + 1 >= d)
                    phase = ST_TAIL;
                else
                begin
                    row_idx++;
                    phase = ST_CELL;
                end
            end
            else
            begin
                col_idx++;
                phase = ST_CELL;
            end
            mag = '0;
            colour_acc = '0;
            hex_digits = 0;
            is_neg = 1'b0;
            nl_taken = 1'b0;
        endfunction

        function void digit_step(logic [7:0] c);
            logic [31:0] dg;
            if (c >= CH_0 && c <= CH_9)
            begin
                dg = c - CH_0;
                // -2147483648 is the only value with a final 8 past the limit
                if (mag > MAG_LIMIT ||
                    (mag == MAG_LIMIT && (dg > 8 || (dg == 8 && !is_neg))))
                    raise_error(1'b0);
                else
                begin
                    mag = mag * 10 + dg;
                    phase = ST_DIGIT;
                end
            end
            else if (c == CH_COMMA)
            begin
                colour_flag = 1'b1;
                phase = ST_COMMA;
            end
            else if (is_blank(c))
                finish_cell(1'b0, 1'b0);
            else
                raise_error(1'b0);
        endfunction

        function void note_char(logic [7:0] c, bit eof);
            int hv;
            if (in_error)
            begin
                if (eof)
                    clear_file();
                return;
            end
            case (phase)
                ST_TAIL:
                begin
                    if (eof)
                    begin
                        add_result(hmtp_pkg::KIND_DONE, '0, '0, 0, 0, 1'b0);
                        clear_file();
                    end
                    else if (!is_blank(c))
                        raise_error(1'b0);
                    return;
                end
                ST_SIGN:
                begin
                    if (!eof && c >= CH_0 && c <= CH_9)
                        digit_step(c);
                    else
                        raise_error(eof);
                    return;
                end
                ST_DIGIT:
                begin
                    if (eof)
                        finish_cell(1'b1, 1'b0);
                    else
                        digit_step(c);
                    return;
                end
                ST_COMMA:
                begin
                    if (!eof && c == CH_0)
                        phase = ST_ZERO;
                    else
                        raise_error(eof);
                    return;
                end
                ST_ZERO:
                begin
                    if (!eof && (c == CH_XL || c == CH_XU))
                    begin
                        phase = ST_HEX;
                        hex_digits = 0;
                        colour_acc = '0;
                    end
                    else
                        raise_error(eof);
                    return;
                end
                ST_HEX:
                begin
                    if (eof)
                    begin
                        finish_cell(1'b1, 1'b1);
                        return;
                    end
                    hv = hex_value(c);
                    if (hex_digits < 6 && hv >= 0)
                    begin
                        colour_acc = {colour_acc[19:0], hv[3:0]};
                        hex_digits++;
                    end
                    else if (is_blank(c))
                        finish_cell(1'b0, 1'b1);
                    else
                        raise_error(1'b0);
                    return;
                end
                ST_BLANK:
                begin
                    if (eof)
                    begin
                        finish_cell(1'b1, 1'b0);
                        return;
                    end
                end
                default:
                begin
                    if (eof)
                    begin
                        raise_error(1'b1);
                        return;
                    end
                end
            endcase
            // cell start: a space or tab re-arms the single newline skip
            if (c == CH_SPACE || c == CH_TAB)
            begin
                nl_taken = 1'b0;
                phase = ST_BLANK;
            end
            else if (c == CH_NL && !nl_taken)
            begin
                nl_taken = 1'b1;
                phase = ST_BLANK;
            end
            else if (c == CH_MINUS)
            begin
                is_neg = 1'b1;
                phase = ST_SIGN;
            end
            else
                digit_step(c);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(hmtp_pkg::result_t got);
            hmtp_pkg::result_t want;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: expected none, actual kind %0d",
                         $time, got.kind);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("altitude", want.altitude, got.altitude);
            compare_field("cell_color", want.color, got.color);
            compare_field("cell_row", want.row, got.row);
            compare_field("cell_col", want.col, got.col);
            compare_field("height_min", want.height_min, got.height_min);
            compare_field("height_max", want.height_max, got.height_max);
            compare_field("color_seen", want.color_seen, got.color_seen);
            compare_field("last_cell", want.last_cell, got.last_cell);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [RES_W-1:0] m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    height_scoreboard sb;
    logic [7:0]       txt[$];
    bit               idle_on;
    bit               long_hold;
    int unsigned      cycle_count;
    string            hex_alpha   = "0123456789abcdefABCDEF";
    string            noise_alpha = "0123456789-,xXaFg \t\n";

    heightmap_text_parser_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Monitor: note accepted characters, check accepted results, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        hmtp_pkg::result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.kind       = m_tuser;
                got.altitude   = m_tdata[31:0];
                got.color      = m_tdata[55:32];
                got.row        = '0;
                got.row[CB-1:0] = m_tdata[ROW_LSB +: CB];
                got.col        = '0;
                got.col[CB-1:0] = m_tdata[COL_LSB +: CB];
                got.height_min = m_tdata[MIN_LSB +: 32];
                got.height_max = m_tdata[MAX_LSB +: 32];
                got.color_seen = m_tdata[SEEN_BIT];
                got.last_cell  = m_tlast;
                sb.check_result(got);
            end
        end
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Called and returns at a falling edge; valid stays high between beats unless a random gap is drawn
    task automatic send_beat(input logic [7:0] c, input bit eof);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eof;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        while (sb.expected_cells.size() != 0)
            @(posedge clk);
        // an ignored character may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < txt.size(); i++)
            send_beat(txt[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        s_tvalid <= 1'b0;
        wait_drain();
    endtask

    task automatic write_grid_reg(input logic idx, input logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {19'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == hmtp_pkg::REG_GRID_WIDTH)
            sb.width_reg = 32'(value);
        else
            sb.depth_reg = 32'(value);
    endtask

    task automatic set_grid(input logic [12:0] w, input logic [12:0] d);
        write_grid_reg(hmtp_pkg::REG_GRID_WIDTH, w);
        write_grid_reg(hmtp_pkg::REG_GRID_DEPTH, d);
    endtask

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            1: return CH_TAB;
            2: return CH_NL;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        return noise_alpha[$urandom_range(0, noise_alpha.len() - 1)];
    endfunction

    // Without allow_double, never two newlines in a row: that would open an empty cell
    function automatic void push_blanks(bit allow_double);
        int unsigned n;
        logic [7:0]  ch;
        bit          prev_nl;
        n = $urandom_range(1, 3);
        prev_nl = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            ch = pick_blank();
            if (!allow_double && prev_nl && ch == CH_NL)
                ch = CH_SPACE;
            txt.push_back(ch);
            prev_nl = (ch == CH_NL);
        end
    endfunction

    function automatic void push_colour();
        int unsigned n;
        txt.push_back(CH_COMMA);
        txt.push_back(CH_0);
        txt.push_back($urandom_range(0, 1) ? CH_XL : CH_XU);
        n = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            txt.push_back(hex_alpha[$urandom_range(0, hex_alpha.len() - 1)]);
    endfunction

    function automatic string gen_height(bit compact);
        int v;
        if (compact)
        begin
            v = int'($urandom_range(0, 19)) - 10;
            return $sformatf("%0d", v);
        end
        case ($urandom_range(0, 31))
            0: return "0";
            1: return "2147483647";
            2: return "-2147483648";
            3: return "";
            4: return "-0";
            5: return $sformatf("00%0d", $urandom_range(0, 99));
            6: return $sformatf("%0d", $urandom_range(0, 32'h7FFFFFFF));
            7: return $sformatf("%0d", int'($urandom));
            8: return $sformatf("-%0d", $urandom_range(0, 32'h7FFFFFFF));
            9:
            begin
                // overflow on the last digit, or a random unsigned value
                case ($urandom_range(0, 3))
                    0: return "2147483648";
                    1: return "-2147483649";
                    2: return "-21474836480";
                    default: return $sformatf("%0d", $urandom);
                endcase
            end
            default:
            begin
                v = int'($urandom_range(0, 1999)) - 1000;
                return $sformatf("%0d", v);
            end
        endcase
    endfunction

    function automatic void build_grid(int unsigned cells, int unsigned row_len, bit compact);
        string h;
        txt.delete();
        if ($urandom_range(0, 3) == 0)
            push_blanks(1'b0);
        for (int unsigned k = 0; k < cells; k++)
        begin
            h = gen_height(compact);
            push_str(h);
            // an empty cell needs a colour part, else the separator swallows it
            if (!compact && (h.len() == 0 || $urandom_range(0, 2) == 0))
                push_colour();
            if (k + 1 < cells)
            begin
                if ((k % row_len == row_len - 1) && $urandom_range(0, 3) != 0)
                    txt.push_back(CH_NL);
                else
                    txt.push_back(pick_blank());
                if ($urandom_range(0, 2) == 0)
                    push_blanks(1'b0);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                txt.push_back(pick_blank());
                push_blanks(1'b1);
            end
        end
    endfunction

    function automatic void build_noise();
        int unsigned n;
        txt.delete();
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
            txt.push_back($urandom_range(0, 1) ? pick_noise() : 8'($urandom_range(0, 255)));
    endfunction

    function automatic void corrupt_text();
        int unsigned pos;
        if (txt.size() == 0)
        begin
            txt.push_back(pick_noise());
            return;
        end
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 3))
            0: txt[pos] = 8'($urandom_range(0, 255));
            1:
            begin
                while (txt.size() > pos)
                    void'(txt.pop_back());
            end
            2: txt.insert(pos, pick_noise());
            default: txt.push_back(pick_noise());
        endcase
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return $urandom_range(5, 8);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned w_val;
        int unsigned d_val;
        int unsigned cells;
        int unsigned random_beats;
        int unsigned file_no;
        int unsigned mode;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        idle_on   = 1'b0;
        long_hold = 1'b0;
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed files on the reset grid of one cell
        txt.delete();
        push_str("-2147483648");        // negative limit, closed by end of file
        send_file();
        txt.delete();                   // end of file at cell start
        send_file();
        txt.delete();
        push_str("\n\n");               // second newline gives an empty cell
        send_file();
        txt.delete();
        push_str(",0xfF");              // lone colour part
        send_file();
        txt.delete();
        push_str(",0X ");               // empty colour
        send_file();
        txt.delete();
        push_str("7x\n");               // error, then ignore until end of file
        send_file();

        // Clamped extremes: a wide row and a tall column, cut short by end of file
        idle_on = 1'b1;
        set_grid(13'h1FFF, 13'd0);
        build_grid(CLAMP_CELLS, 1 << CB, 1'b1);
        send_file();
        set_grid(13'd0, 13'd4096);
        build_grid(CLAMP_CELLS, 1, 1'b1);
        send_file();

        // Random files
        random_beats = 0;
        file_no = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            file_no++;
            idle_on = (random_beats < RANDOM_BEATS - 150) && ($urandom_range(0, 3) != 0);
            if (file_no == HOLD_FILE)
            begin
                // keep offering beats so the parser fills up behind the held output
                idle_on = 1'b0;
                w_val = 6;
                d_val = 6;
            end
            else
            begin
                w_val = pick_size();
                d_val = pick_size();
            end
            set_grid(13'(w_val), 13'(d_val));
            cells = sb.clamp_size(w_val) * sb.clamp_size(d_val);
            mode = (file_no == HOLD_FILE) ? 0 : $urandom_range(0, 9);
            if (mode == 9)
                build_noise();
            else
            begin
                if (mode == 8)
                    cells = $urandom_range(0, 1) ? cells + 1 : cells - 1;
                build_grid(cells, sb.clamp_size(w_val), 1'b0);
                if (mode == 7)
                    corrupt_text();
            end
            if (file_no == HOLD_FILE)
                long_hold = 1'b1;
            random_beats += txt.size() + 1;
            send_file();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_cells.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
